// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, quiet while in reset
`define ASSERT_CLK(lbl, clk_s, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication, quiet while in reset
`define ASSERT_IMPL(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/gtpvc_pkg.sv
package gtpvc_pkg;

	// fixed field widths
	localparam int SPEED_W    = 11;
	localparam int TURN_W     = 12;
	localparam int DEADBAND_W = 12;
	localparam int STOP_W     = 16;
	localparam int GAIN_W     = 11;

	// fixed point
	localparam int GUARD_BITS   = 12;
	localparam int GAIN_BITS    = 10;
	localparam int ZW           = 34;
	localparam int DCLAMP_W     = 21;
	localparam int INV_K_W      = 16;
	localparam logic [INV_K_W-1:0] INV_GAIN_Q16 = 16'd39797;
	localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;

	// register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_DIST  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIM  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_LIM   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DONE_SPEED = 3'd7;

	// reset values
	localparam logic [DEADBAND_W-1:0] RST_DEADBAND   = 12'd179;
	localparam logic [STOP_W-1:0]     RST_STOP_DIST  = 16'd51;
	localparam logic [GAIN_W-1:0]     RST_SPEED_GAIN = 11'd205;
	localparam logic [SPEED_W-1:0]    RST_SPEED_LIM  = 11'd205;
	localparam logic [SPEED_W-1:0]    RST_TURN_LIM   = 11'd715;
	localparam logic [SPEED_W-1:0]    RST_DONE_SPEED = 11'd10;

	// control settings seen by the output math
	typedef struct packed {
		logic [DEADBAND_W-1:0] angle_deadband;
		logic [STOP_W-1:0]     stop_distance;
		logic [GAIN_W-1:0]     speed_gain;
		logic [SPEED_W-1:0]    speed_limit;
		logic [SPEED_W-1:0]    turn_limit;
		logic [SPEED_W-1:0]    done_speed;
	} cfg_t;

	// atan(2^-i) in q30, truncated
	function automatic logic [ZW-1:0] atan_q30(input int idx);
		logic [ZW-1:0] v;
		case (idx)
			0:       v = 34'd843314856;
			1:       v = 34'd497837829;
			2:       v = 34'd263043836;
			3:       v = 34'd133525158;
			4:       v = 34'd67021686;
			5:       v = 34'd33543515;
			6:       v = 34'd16775850;
			7:       v = 34'd8388437;
			8:       v = 34'd4194282;
			9:       v = 34'd2097149;
			10:      v = 34'd1048575;
			11:      v = 34'd524287;
			12:      v = 34'd262143;
			13:      v = 34'd131071;
			14:      v = 34'd65535;
			15:      v = 34'd32767;
			16:      v = 34'd16383;
			17:      v = 34'd8191;
			18:      v = 34'd4095;
			19:      v = 34'd2047;
			20:      v = 34'd1023;
			21:      v = 34'd511;
			22:      v = 34'd255;
			23:      v = 34'd127;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/gtpvc_cell.sv
`include "assert_macros.svh"

module gtpvc_cell #(
	parameter int XW    = 31,
	parameter int STAGE = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [XW-1:0]           x_in,
	input  logic signed [XW-1:0]           y_in,
	input  logic signed [gtpvc_pkg::ZW-1:0] z_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [XW-1:0]           x_out,
	output logic signed [XW-1:0]           y_out,
	output logic signed [gtpvc_pkg::ZW-1:0] z_out
);

	localparam logic signed [gtpvc_pkg::ZW-1:0] ATAN =
		$signed(gtpvc_pkg::atan_q30(STAGE));

	logic                            vld_q;
	logic signed [XW-1:0]            x_q, y_q;
	logic signed [gtpvc_pkg::ZW-1:0] z_q;
	logic signed [XW-1:0]            xs, ys;
	logic                            neg_y;

	assign in_ready = !vld_q || out_ready;
	assign xs       = x_in >>> STAGE;
	assign ys       = y_in >>> STAGE;
	assign neg_y    = y_in[XW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	// one micro-rotation toward the x axis
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			if (neg_y) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ATAN;
			end else begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ATAN;
			end
		end
	end

	assign out_valid = vld_q;
	assign x_out     = x_q;
	assign y_out     = y_q;
	assign z_out     = z_q;

	`ASSERT_CLK(a_cell_hold, clk, arst_n, vld_q && !out_ready |=> vld_q && $stable(z_q), "cell word lost under stall")
	`ASSERT_IMPL(a_cell_xpos, clk, arst_n, vld_q, !x_q[XW-1], "cordic x went negative")

endmodule

// File: rtl/gtpvc_post.sv
`include "assert_macros.svh"

module gtpvc_post #(
	parameter int XW        = 31,
	parameter int FRAC_BITS = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  gtpvc_pkg::cfg_t                        cfg,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [XW-1:0]                   x_in,
	input  logic signed [gtpvc_pkg::ZW-1:0]        z_in,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [gtpvc_pkg::SPEED_W-1:0]          speed,
	output logic signed [gtpvc_pkg::TURN_W-1:0]    turn_rate,
	output logic                                   done_res
);

	localparam int ZW    = gtpvc_pkg::ZW;
	localparam int SW    = gtpvc_pkg::SPEED_W;
	localparam int TW    = gtpvc_pkg::TURN_W;
	localparam int CW    = gtpvc_pkg::DCLAMP_W;
	localparam int GW    = gtpvc_pkg::GAIN_W;
	localparam int KW    = gtpvc_pkg::INV_K_W;
	localparam int SHIFT = 30 - FRAC_BITS;
	localparam int BW    = FRAC_BITS + 4;
	localparam int NW    = BW + 2;
	localparam int QW    = NW - 3;
	localparam int TQW   = (QW > SW) ? QW : SW;
	localparam int MW    = (BW > gtpvc_pkg::DEADBAND_W) ? BW : gtpvc_pkg::DEADBAND_W;
	localparam int LOW   = 24;
	localparam int XHW   = XW - LOW;
	localparam int PW    = XW + KW;
	localparam int DW    = XW - 12;
	localparam int DBW   = (DW > CW + 1) ? DW : CW + 1;
	localparam int DSH   = gtpvc_pkg::GUARD_BITS + 16;
	localparam int PRW   = CW + GW;
	localparam int RW    = NW + 1;
	localparam int MPW   = 2 * NW + 1;
	localparam longint RECIP = ((longint'(1) << (NW + 4)) + 8) / 9;
	localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
	localparam logic signed [ZW-1:0] ROUND_V = ZW'(64'd1 << (SHIFT - 1));

	// valid / ready chain
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4   = !vld_s4 || out_ready;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	// stage 1: gain products and rounded bearing
	logic signed [ZW-1:0] zr, zs;
	logic signed [BW-1:0] brg;
	logic [BW-1:0]        mag;
	logic [LOW+KW-1:0]    plo;
	logic [XHW+KW-1:0]    phi;

	assign zr  = z_in + ROUND_V;
	assign zs  = zr >>> SHIFT;
	assign brg = zs[BW-1:0];
	assign mag = brg[BW-1] ? BW'(-brg) : BW'(brg);
	assign plo = {{KW{1'b0}}, x_in[LOW-1:0]} * {{LOW{1'b0}}, gtpvc_pkg::INV_GAIN_Q16};
	assign phi = {{KW{1'b0}}, x_in[XW-1:LOW]} * {{XHW{1'b0}}, gtpvc_pkg::INV_GAIN_Q16};

	logic [LOW+KW-1:0] plo_s1;
	logic [XHW+KW-1:0] phi_s1;
	logic [BW-1:0]     mag_s1;
	logic              neg_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			plo_s1 <= plo;
			phi_s1 <= phi;
			mag_s1 <= mag;
			neg_s1 <= brg[BW-1];
		end
	end

	// stage 2: distance, stop test, turn division by nine
	logic [PW-1:0]  dsum;
	logic [DBW-1:0] dext;
	logic [CW-1:0]  dclamp;
	logic [NW-1:0]  nt;
	logic [MPW-1:0] tprod;

	assign dsum   = PW'(plo_s1) + (PW'(phi_s1) << LOW) + (PW'(1) << (DSH - 1));
	assign dext   = DBW'(dsum[PW-1:DSH]);
	assign dclamp = (|dext[DBW-1:CW]) ? {CW{1'b1}} : dext[CW-1:0];
	assign nt     = NW'({mag_s1, 1'b0}) + NW'(4);
	assign tprod  = MPW'(nt) * MPW'(RECIP_V);

	logic [CW-1:0] dist_s2;
	logic          far_s2;
	logic [QW-1:0] tq_s2;
	logic          turn_on_s2;
	logic          neg_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			dist_s2    <= dclamp;
			far_s2     <= dext > DBW'(cfg.stop_distance);
			tq_s2      <= tprod[MPW-1:NW+4];
			turn_on_s2 <= MW'(mag_s1) > MW'(cfg.angle_deadband);
			neg_s2     <= neg_s1;
		end
	end

	// stage 3: turn saturation and sign, speed product
	logic [TQW-1:0]       tq_ext;
	logic [SW-1:0]        tmag;
	logic signed [TW-1:0] turn;
	logic [PRW-1:0]       sprod;

	assign tq_ext = TQW'(tq_s2);
	assign tmag   = (tq_ext > TQW'(cfg.turn_limit)) ? cfg.turn_limit : tq_ext[SW-1:0];
	assign turn   = !turn_on_s2 ? '0 :
		neg_s2 ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
	assign sprod  = PRW'(dist_s2) * PRW'(cfg.speed_gain);

	logic signed [TW-1:0] turn_s3;
	logic [PRW-1:0]       sprod_s3;
	logic                 far_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			turn_s3  <= turn;
			sprod_s3 <= sprod;
			far_s3   <= far_s2;
		end
	end

	// stage 4: speed rounding, saturation, done flag
	logic [PRW-1:0]                 sround;
	logic [PRW-gtpvc_pkg::GAIN_BITS-1:0] sq;
	logic [SW-1:0]                  scap, spd;

	assign sround = sprod_s3 + PRW'(1 << (gtpvc_pkg::GAIN_BITS - 1));
	assign sq     = sround[PRW-1:gtpvc_pkg::GAIN_BITS];
	assign scap   = (sq > (PRW-gtpvc_pkg::GAIN_BITS)'(cfg.speed_limit)) ?
		cfg.speed_limit : sq[SW-1:0];
	assign spd    = far_s3 ? scap : '0;

	logic [SW-1:0]        speed_s4;
	logic signed [TW-1:0] turn_s4;
	logic                 done_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			speed_s4 <= spd;
			turn_s4  <= turn_s3;
			done_s4  <= spd < cfg.done_speed;
		end
	end

	assign out_valid = vld_s4;
	assign speed     = speed_s4;
	assign turn_rate = turn_s4;
	assign done_res  = done_s4;

	`ASSERT_CLK(a_post_s3_hold, clk, arst_n, vld_s3 && vld_s4 && !out_ready |=> vld_s3, "stage 3 dropped while output stalled")
	`ASSERT_CLK(a_post_advance, clk, arst_n, vld_s1 && rdy_s2 |=> vld_s2, "stage 1 word not handed on")

endmodule

// File: rtl/go_to_point_velocity_controller.sv
// go-to-point velocity controller: each input word is one robot position
// (current_x, current_y, in 1/2^10 m); the target comes from config
// registers 0 and 1. The offset to the target runs through a chain of
// CORDIC_STAGES vectoring cells that give distance and absolute bearing
// (atan2, heading is not used), then a four stage output pipe gives one
// result word: speed (distance times gain, zero at or below stop_distance,
// capped to speed_limit), turn_rate (bearing times 2/9, zero inside the
// angle deadband, capped to turn_limit) and done_res (speed below
// done_speed). One word is taken per clock unless the output stalls and
// the pipe is full; a result passes through the entry register, the
// CORDIC_STAGES cells and the four output stages, each holding one word.
// Every stage carries its own valid and only stalls when the stage after it
// is full, so the input keeps accepting while a result waits at the output,
// until the pipe fills. Config is written through cfg_we / cfg_index /
// cfg_data with no wait and should only change while the pipe is empty.
`include "assert_macros.svh"

module go_to_point_velocity_controller #(
	parameter int POS_WIDTH     = 16,
	parameter int FRAC_BITS     = 10,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [gtpvc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [((POS_WIDTH > 16) ? POS_WIDTH : 16)-1:0] cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  logic signed [POS_WIDTH-1:0]              current_x,
	input  logic signed [POS_WIDTH-1:0]              current_y,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output logic [gtpvc_pkg::SPEED_W-1:0]            speed,
	output logic signed [gtpvc_pkg::TURN_W-1:0]      turn_rate,
	output logic                                     done_res
);

	localparam int ZW = gtpvc_pkg::ZW;
	localparam int DW = POS_WIDTH + 1;   // exact offset width
	localparam int XW = POS_WIDTH + 15;  // offset scaled by 2^12 plus cordic growth

	// config registers
	logic signed [POS_WIDTH-1:0]          tgt_x_q, tgt_y_q;
	logic [gtpvc_pkg::DEADBAND_W-1:0]     deadband_q;
	logic [gtpvc_pkg::STOP_W-1:0]         stop_q;
	logic [gtpvc_pkg::GAIN_W-1:0]         gain_q;
	logic [gtpvc_pkg::SPEED_W-1:0]        slim_q, tlim_q, done_q;
	gtpvc_pkg::cfg_t                      cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_x_q    <= '0;
			tgt_y_q    <= '0;
			deadband_q <= gtpvc_pkg::RST_DEADBAND;
			stop_q     <= gtpvc_pkg::RST_STOP_DIST;
			gain_q     <= gtpvc_pkg::RST_SPEED_GAIN;
			slim_q     <= gtpvc_pkg::RST_SPEED_LIM;
			tlim_q     <= gtpvc_pkg::RST_TURN_LIM;
			done_q     <= gtpvc_pkg::RST_DONE_SPEED;
		end else if (cfg_we) begin
			// upper data bits beyond each register are dropped
			case (cfg_index)
				gtpvc_pkg::REG_TARGET_X:   tgt_x_q    <= cfg_data[POS_WIDTH-1:0];
				gtpvc_pkg::REG_TARGET_Y:   tgt_y_q    <= cfg_data[POS_WIDTH-1:0];
				gtpvc_pkg::REG_DEADBAND:   deadband_q <= cfg_data[gtpvc_pkg::DEADBAND_W-1:0];
				gtpvc_pkg::REG_STOP_DIST:  stop_q     <= cfg_data[gtpvc_pkg::STOP_W-1:0];
				gtpvc_pkg::REG_SPEED_GAIN: gain_q     <= cfg_data[gtpvc_pkg::GAIN_W-1:0];
				gtpvc_pkg::REG_SPEED_LIM:  slim_q     <= cfg_data[gtpvc_pkg::SPEED_W-1:0];
				gtpvc_pkg::REG_TURN_LIM:   tlim_q     <= cfg_data[gtpvc_pkg::SPEED_W-1:0];
				gtpvc_pkg::REG_DONE_SPEED: done_q     <= cfg_data[gtpvc_pkg::SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.angle_deadband = deadband_q;
	assign cfg.stop_distance  = stop_q;
	assign cfg.speed_gain     = gain_q;
	assign cfg.speed_limit    = slim_q;
	assign cfg.turn_limit     = tlim_q;
	assign cfg.done_speed     = done_q;

	// entry stage: offset to target, fold left half plane by a half turn
	logic signed [DW-1:0] dx, dy;
	logic signed [XW-1:0] dx_e, dy_e, x0, y0;
	logic signed [ZW-1:0] z0;
	logic                 left;

	assign dx   = $signed({tgt_x_q[POS_WIDTH-1], tgt_x_q}) -
		$signed({current_x[POS_WIDTH-1], current_x});
	assign dy   = $signed({tgt_y_q[POS_WIDTH-1], tgt_y_q}) -
		$signed({current_y[POS_WIDTH-1], current_y});
	assign dx_e = $signed({{(XW-DW){dx[DW-1]}}, dx});
	assign dy_e = $signed({{(XW-DW){dy[DW-1]}}, dy});
	assign left = dx[DW-1];
	assign x0   = (left ? -dx_e : dx_e) <<< gtpvc_pkg::GUARD_BITS;
	assign y0   = (left ? -dy_e : dy_e) <<< gtpvc_pkg::GUARD_BITS;
	// start angle: zero in the right half plane; in the left, +pi above or on the axis, -pi below
	assign z0   = !left ? '0 : (dy[DW-1] ? -gtpvc_pkg::PI_Q30 : gtpvc_pkg::PI_Q30);

	logic                 vld_s1, rdy_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;

	// cell chain links; link 0 is the entry stage
	logic                 vld_c [CORDIC_STAGES+1];
	logic                 rdy_c [CORDIC_STAGES+1];
	logic signed [XW-1:0] x_c   [CORDIC_STAGES+1];
	logic signed [XW-1:0] y_c   [CORDIC_STAGES+1];
	logic signed [ZW-1:0] z_c   [CORDIC_STAGES+1];

	assign rdy_s1   = !vld_s1 || rdy_c[0];
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			x_s1 <= x0;
			y_s1 <= y0;
			z_s1 <= z0;
		end
	end

	assign vld_c[0] = vld_s1;
	assign x_c[0]   = x_s1;
	assign y_c[0]   = y_s1;
	assign z_c[0]   = z_s1;

	// vectoring chain: each cell rotates one step and hands on its word
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		gtpvc_cell #(
			.XW    (XW),
			.STAGE (g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_c[g]),
			.in_ready  (rdy_c[g]),
			.x_in      (x_c[g]),
			.y_in      (y_c[g]),
			.z_in      (z_c[g]),
			.out_valid (vld_c[g+1]),
			.out_ready (rdy_c[g+1]),
			.x_out     (x_c[g+1]),
			.y_out     (y_c[g+1]),
			.z_out     (z_c[g+1])
		);
	end

	// distance / bearing to speed and turn commands, output register
	gtpvc_post #(
		.XW        (XW),
		.FRAC_BITS (FRAC_BITS)
	) u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (vld_c[CORDIC_STAGES]),
		.in_ready  (rdy_c[CORDIC_STAGES]),
		.x_in      (x_c[CORDIC_STAGES]),
		.z_in      (z_c[CORDIC_STAGES]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.speed     (speed),
		.turn_rate (turn_rate),
		.done_res  (done_res)
	);

	`ASSERT_CLK(a_top_entry_load, clk, arst_n, in_valid && in_ready |=> vld_s1, "accepted word missing from entry stage")

endmodule

// File: bench/tb_go_to_point_velocity_controller.sv
`timescale 1ns / 100ps

module tb_go_to_point_velocity_controller;

	localparam int POS_W = 16;
	localparam int LATENCY = 21;                     // entry register, 16 cordic cells and 4 output stages
	localparam longint HALF_TURN_Q30 = 64'sd3373259426;
	localparam longint INV_GAIN_Q16 = 39797;
	localparam longint DIST_ROUND = 134217728;       // half lsb of the >> 28 gain compensation
	localparam longint BEARING_ROUND = 524288;       // half lsb of q30 -> 1/1024 rad
	localparam int MAX_REPORTS = 50;

	// one result word as the block should give it
	typedef struct packed {
		logic [gtpvc_pkg::SPEED_W-1:0] speed;
		logic [gtpvc_pkg::TURN_W-1:0]  turn;
		logic                          done;
	} cmd_t;

	// dut ports, all inputs known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [gtpvc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [POS_W-1:0] current_x = '0;
	logic signed [POS_W-1:0] current_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [gtpvc_pkg::SPEED_W-1:0] speed;
	logic signed [gtpvc_pkg::TURN_W-1:0] turn_rate;
	logic done_res;

	// shadow of the register file, starts at the reset values
	logic signed [POS_W-1:0] goal_x = '0;
	logic signed [POS_W-1:0] goal_y = '0;
	logic [11:0] deadband = 12'd179;
	logic [15:0] stop_dist = 16'd51;
	logic [10:0] gain = 11'd205;
	logic [10:0] speed_cap = 11'd205;
	logic [10:0] turn_cap = 11'd715;
	logic [10:0] done_thresh = 11'd10;

	// atan(2^-i) in q30, truncated
	longint arctan_q30 [16] = '{
		843314856, 497837829, 263043836, 133525158,
		67021686, 33543515, 16775850, 8388437,
		4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767
	};

	cmd_t pending_cmds [$];   // commands still owed by the block, oldest first
	int mismatches = 0;
	bit sender_idle = 1'b1;   // random gaps on the input side
	bit receiver_idle = 1'b1; // random stalls on the output side
	int hold_request = 0;     // one-shot long output stall, in cycles

	go_to_point_velocity_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.current_x (current_x),
		.current_y (current_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.speed     (speed),
		.turn_rate (turn_rate),
		.done_res  (done_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// global watchdog, far above the slowest legal run
	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

	// velocity command for one position under the current settings
	function automatic cmd_t predict_command(input logic signed [POS_W-1:0] px,
			input logic signed [POS_W-1:0] py);
		longint dx, dy, x, y, z, xs, ys, range_m, bearing, mag, turn_mag, spd;
		cmd_t c;
		dx = longint'(goal_x) - longint'(px);
		dy = longint'(goal_y) - longint'(py);
		// left half plane: rotate by pi first so the cells converge
		if (dx < 0) begin
			x = -dx * 4096;
			y = -dy * 4096;
			z = (dy >= 0) ? HALF_TURN_Q30 : -HALF_TURN_Q30;
		end else begin
			x = dx * 4096;
			y = dy * 4096;
			z = 0;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y < 0) begin
				x = x - ys;
				y = y + xs;
				z = z - arctan_q30[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + arctan_q30[i];
			end
		end
		range_m = (x * INV_GAIN_Q16 + DIST_ROUND) >>> 28;
		bearing = (z + BEARING_ROUND) >>> 20;
		mag = (bearing < 0) ? -bearing : bearing;
		// 2/9 of the bearing, rounded, outside the deadband only
		turn_mag = 0;
		if (mag > longint'(deadband)) begin
			turn_mag = (2 * mag + 4) / 9;
			if (turn_mag > longint'(turn_cap))
				turn_mag = longint'(turn_cap);
		end
		spd = 0;
		if (range_m > longint'(stop_dist)) begin
			spd = (range_m * longint'(gain) + 512) >>> 10;
			if (spd > longint'(speed_cap))
				spd = longint'(speed_cap);
		end
		c.speed = 11'(spd);
		c.turn = (bearing < 0) ? 12'(-turn_mag) : 12'(turn_mag);
		c.done = (spd < longint'(done_thresh));
		return c;
	endfunction

	// idle length: mostly short, now and then a long one
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// register value: limits, in-range, or anything the register holds, maybe with stray high bits
	function automatic logic [15:0] choose_level(input int lo, input int hi, input int w);
		logic [15:0] v;
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			v = 16'(lo);
		else if (r < 30)
			v = 16'(hi);
		else if (r < 75)
			v = 16'($urandom_range(lo, hi));
		else
			v = 16'($urandom_range(0, (1 << w) - 1));
		if (w < 16 && $urandom_range(0, 3) == 0)
			v = v | (16'($urandom()) & ~((16'd1 << w) - 16'd1));
		return v;
	endfunction

	function automatic logic [15:0] pick_target();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic signed [POS_W-1:0] corner_coord(input logic signed [POS_W-1:0] g);
		case ($urandom_range(0, 4))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return g;
		endcase
	endfunction

	// single register write, block must be idle
	task automatic write_reg(input logic [gtpvc_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			gtpvc_pkg::REG_TARGET_X:   goal_x = data;
			gtpvc_pkg::REG_TARGET_Y:   goal_y = data;
			gtpvc_pkg::REG_DEADBAND:   deadband = data[11:0];
			gtpvc_pkg::REG_STOP_DIST:  stop_dist = data;
			gtpvc_pkg::REG_SPEED_GAIN: gain = data[10:0];
			gtpvc_pkg::REG_SPEED_LIM:  speed_cap = data[10:0];
			gtpvc_pkg::REG_TURN_LIM:   turn_cap = data[10:0];
			gtpvc_pkg::REG_DONE_SPEED: done_thresh = data[10:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [15:0] tx, input logic [15:0] ty,
			input logic [15:0] db, input logic [15:0] sd, input logic [15:0] g,
			input logic [15:0] sl, input logic [15:0] tl, input logic [15:0] ds);
		write_reg(gtpvc_pkg::REG_TARGET_X, tx);
		write_reg(gtpvc_pkg::REG_TARGET_Y, ty);
		write_reg(gtpvc_pkg::REG_DEADBAND, db);
		write_reg(gtpvc_pkg::REG_STOP_DIST, sd);
		write_reg(gtpvc_pkg::REG_SPEED_GAIN, g);
		write_reg(gtpvc_pkg::REG_SPEED_LIM, sl);
		write_reg(gtpvc_pkg::REG_TURN_LIM, tl);
		write_reg(gtpvc_pkg::REG_DONE_SPEED, ds);
	endtask

	task automatic apply_random_settings();
		logic [15:0] sd;
		// stop distance mostly small so speed is not always zero
		sd = ($urandom_range(0, 3) == 0) ? choose_level(0, 65535, 16) : 16'($urandom_range(0, 600));
		apply_settings(pick_target(), pick_target(), choose_level(0, 3217, 12), sd,
			choose_level(0, 1024, 11), choose_level(0, 1024, 11),
			choose_level(0, 1024, 11), choose_level(0, 1024, 11));
	endtask

	// offer one position word and hold it until taken, then maybe idle
	task automatic send_position(input logic signed [POS_W-1:0] px,
			input logic signed [POS_W-1:0] py);
		cmd_t want;
		int gap;
		want = predict_command(px, py);
		in_valid <= 1'b1;
		current_x <= px;
		current_y <= py;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_cmds.push_back(want);
		gap = (sender_idle && $urandom_range(0, 99) < 40) ? gap_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// position mix: far, near the goal, on the goal axes, corners, mid range
	task automatic send_random_position();
		logic signed [POS_W-1:0] px, py;
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			px = POS_W'($urandom());
			py = POS_W'($urandom());
		end else if (r < 55) begin
			px = POS_W'(int'(goal_x) + int'($urandom_range(0, 400)) - 200);
			py = POS_W'(int'(goal_y) + int'($urandom_range(0, 400)) - 200);
		end else if (r < 70) begin
			if ($urandom_range(0, 1)) begin
				px = goal_x;
				py = POS_W'($urandom());
			end else begin
				px = POS_W'($urandom());
				py = goal_y;
			end
		end else if (r < 80) begin
			px = corner_coord(goal_x);
			py = corner_coord(goal_y);
		end else begin
			px = POS_W'(int'(goal_x) + int'($urandom_range(0, 8000)) - 4000);
			py = POS_W'(int'(goal_y) + int'($urandom_range(0, 8000)) - 4000);
		end
		send_position(px, py);
	endtask

	// drop valid and wait until every owed command has come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// reset settings: zero offset, both pi starts, stop distance, deadband, corners
	task automatic test_reset_defaults();
		send_position(16'sd0, 16'sd0);
		send_position(16'sd100, 16'sd0);
		send_position(16'sd100, 16'sd5);
		send_position(-16'sd40, 16'sd0);
		send_position(-16'sd2000, 16'sd30);
		send_position(16'sh8000, 16'sh8000);
		send_position(16'sh7fff, 16'sh7fff);
		send_position(16'sh7fff, 16'sh8000);
		send_position(16'sh8000, 16'sh7fff);
		send_position(-16'sd1, -16'sd1);
		drain_results();
	endtask

	// settings at their floor, then at their ceiling with stray high bits, then top of range but for the deadband
	task automatic test_register_extremes();
		apply_settings(16'h8000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000);
		send_position(16'sh7fff, 16'sh8000);
		send_position(16'sh8000, 16'sh7fff);
		send_position(16'sd0, 16'sd0);
		send_position(16'sh8000, 16'sh8000);
		drain_results();
		apply_settings(16'h7fff, 16'h8000, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			16'hffff);
		send_position(16'sh8000, 16'sh7fff);
		send_position(16'sh7fff, 16'sh8000);
		send_position(16'sh8000, 16'sh8000);
		drain_results();
		apply_settings(16'h0000, 16'h0000, 16'hf000, 16'h0000, 16'd1024, 16'd1024, 16'd1024,
			16'd1024);
		send_position(16'sd1000, 16'sd0);
		send_position(16'sd0, 16'sd1000);
		send_position(-16'sd1000, -16'sd3);
		send_position(-16'sd5000, 16'sd0);
		drain_results();
	endtask

	// back to back words, no gaps or stalls on either side
	task automatic test_full_rate();
		apply_random_settings();
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		repeat (150) send_random_position();
		drain_results();
		sender_idle = 1'b1;
		receiver_idle = 1'b1;
	endtask

	// long output stall while words keep coming, pipe fills and input stalls
	task automatic test_output_backpressure();
		apply_random_settings();
		sender_idle = 1'b0;
		hold_request = 400;
		@(posedge clk);
		repeat (80) send_random_position();
		drain_results();
		sender_idle = 1'b1;
	endtask

	// bursts with the sender waiting for the pipe to empty in between
	task automatic test_drain_pause();
		apply_random_settings();
		repeat (3) begin
			repeat (25) send_random_position();
			drain_results();
		end
	endtask

	task automatic test_random_settings();
		repeat (8) begin
			apply_random_settings();
			repeat (190) send_random_position();
			drain_results();
		end
	endtask

	task automatic flag_mismatch(input string what, input logic signed [31:0] want,
			input logic signed [31:0] got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endtask

	// output side: random stalls, plus the one-shot long hold counted here
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end else if (stall_left == 0 && receiver_idle && $urandom_range(0, 99) < 35) begin
				stall_left = gap_length();
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// every word taken from the output is checked against the oldest owed command
	always @(posedge clk) begin : result_check
		cmd_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_cmds.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result word with nothing owed, speed %0d turn %0d done %0b",
						$time, speed, turn_rate, done_res);
			end else begin
				want = pending_cmds.pop_front();
				if (speed !== want.speed)
					flag_mismatch("speed", 32'(want.speed), 32'(speed));
				if (turn_rate !== want.turn)
					flag_mismatch("turn_rate", 32'($signed(want.turn)), 32'(turn_rate));
				if (done_res !== want.done)
					flag_mismatch("done_res", 32'(want.done), 32'(done_res));
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_full_rate();
		test_output_backpressure();
		test_drain_pause();
		test_random_settings();

		// nothing owed any more, give stray words time to show up
		drain_results();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
